>>> hw/rtl/char_lcd_dirty_refresh_macros.svh
// ----------------------------------------------------------------------------
// char_lcd_dirty_refresh_macros.svh
// Assertion helpers used by the character LCD refresh sequencer.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_DIRTY_REFRESH_MACROS_SVH
`define CHAR_LCD_DIRTY_REFRESH_MACROS_SVH

// Check that a consequence holds in the same cycle as its antecedent
`define CLDR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequence holds in the cycle after its antecedent
`define CLDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cldr_pkg.sv
// ----------------------------------------------------------------------------
// cldr_pkg
// Shared types, codes, reset values and init tables of the LCD refresh block.
// ----------------------------------------------------------------------------
package cldr_pkg;

    // Default geometry: two rows of sixteen cells
    localparam int CELL_COUNT_DEF = 32;
    localparam int ROW_LENGTH_DEF = 16;

    // Input operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ENABLE_PULSE = 3'd0;
    localparam logic [2:0] CFG_CHAR_SETTLE  = 3'd1;
    localparam logic [2:0] CFG_CLEAR_SETTLE = 3'd2;
    localparam logic [2:0] CFG_POWER_WAIT   = 3'd3;
    localparam logic [2:0] CFG_INIT_FIRST   = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  ENABLE_PULSE_RST = 8'd1;
    localparam logic [15:0] CHAR_SETTLE_RST  = 16'd20;
    localparam logic [15:0] CLEAR_SETTLE_RST = 16'd1000;
    localparam logic [16:0] POWER_WAIT_RST   = 17'd100000;
    localparam logic [15:0] INIT_FIRST_RST   = 16'd4100;

    // Sequencer phases: power-on wait, init nibbles 1..14, idle, byte halves
    localparam logic [4:0] PH_POWER     = 5'd0;
    localparam logic [4:0] PH_INIT_FIRST = 5'd1;
    localparam logic [4:0] PH_INIT_LAST = 5'd14;
    localparam logic [4:0] PH_IDLE      = 5'd15;
    localparam logic [4:0] PH_HIGH      = 5'd16;
    localparam logic [4:0] PH_LOW       = 5'd17;

    // Timer limits and fixed settle times
    localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;
    localparam logic [16:0] SHORT_SETTLE_US = 17'd1;
    localparam logic [16:0] LONG_SETTLE_US  = 17'd100;

    // Byte codes that the sequencer treats specially
    localparam logic [8:0] BYTE_CLEAR_DISPLAY = 9'h001;
    localparam logic [1:0] SET_ADDRESS_TOP    = 2'b01;

    // Item kinds after classification
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_WRITE,
        KIND_CLEAR,
        KIND_TICK
    } cldr_kind_t;

    typedef struct packed {
        cldr_kind_t  kind;
        logic [4:0]  position;
        logic [7:0]  char_code;
    } cldr_item_t;

    // Timing configuration as seen by the sequencer
    typedef struct packed {
        logic [7:0]  enable_pulse_us;
        logic [15:0] char_settle_us;
        logic [15:0] clear_settle_us;
        logic [16:0] power_on_wait_us;
        logic [15:0] init_first_wait_us;
    } cldr_cfg_t;

    // Settle classes of the init nibbles
    typedef enum logic [1:0] {
        SETTLE_SHORT,
        SETTLE_LONG,
        SETTLE_FIRST,
        SETTLE_CLEAR
    } cldr_settle_t;

    // Init nibbles: 3,3,3,2 then 0x28, 0x08, 0x01, 0x06, 0x0C in halves
    function automatic logic [3:0] init_nibble(input logic [3:0] step);
        logic [3:0] nib;
        case (step)
            4'd0:    nib = 4'h3;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h2;
            4'd4:    nib = 4'h2;
            4'd5:    nib = 4'h8;
            4'd6:    nib = 4'h0;
            4'd7:    nib = 4'h8;
            4'd8:    nib = 4'h0;
            4'd9:    nib = 4'h1;
            4'd10:   nib = 4'h0;
            4'd11:   nib = 4'h6;
            4'd12:   nib = 4'h0;
            4'd13:   nib = 4'hC;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    // Settle class after each init nibble
    function automatic cldr_settle_t init_settle(input logic [3:0] step);
        cldr_settle_t s;
        case (step)
            4'd0:    s = SETTLE_FIRST;
            4'd1:    s = SETTLE_LONG;
            4'd2:    s = SETTLE_LONG;
            4'd3:    s = SETTLE_LONG;
            4'd4:    s = SETTLE_SHORT;
            4'd5:    s = SETTLE_LONG;
            4'd6:    s = SETTLE_SHORT;
            4'd7:    s = SETTLE_LONG;
            4'd8:    s = SETTLE_SHORT;
            4'd9:    s = SETTLE_CLEAR;
            4'd10:   s = SETTLE_SHORT;
            4'd11:   s = SETTLE_LONG;
            4'd12:   s = SETTLE_SHORT;
            4'd13:   s = SETTLE_LONG;
            default: s = SETTLE_SHORT;
        endcase
        return s;
    endfunction

endpackage

>>> hw/rtl/cldr_front.sv
// ----------------------------------------------------------------------------
// cldr_front
// Input stage: accepts items, classifies the operation and range-checks the
// cell position, then hands the item to the queue.
// ----------------------------------------------------------------------------
module cldr_front #(
    parameter int CELL_COUNT = cldr_pkg::CELL_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [4:0]         position,
    input  logic [7:0]         char_code,
    input  logic               q_full,
    output logic               q_push,
    output cldr_pkg::cldr_item_t q_item
);

    logic                 f_valid_reg;
    cldr_pkg::cldr_item_t f_item_reg;
    cldr_pkg::cldr_item_t f_item_next;
    logic                 accept;

    // Hold the stage while the queue is full
    assign in_stall = f_valid_reg & q_full;
    assign accept   = in_valid & ~in_stall;
    assign q_push   = f_valid_reg & ~q_full;
    assign q_item   = f_item_reg;

    // Classify the operation; drop writes beyond the last cell
    always_comb
    begin
        f_item_next.position  = position;
        f_item_next.char_code = char_code;
        case (op)
            cldr_pkg::OP_WRITE:
            begin
                if (int'(position) < CELL_COUNT)
                    f_item_next.kind = cldr_pkg::KIND_WRITE;
                else
                    f_item_next.kind = cldr_pkg::KIND_NONE;
            end
            cldr_pkg::OP_CLEAR: f_item_next.kind = cldr_pkg::KIND_CLEAR;
            cldr_pkg::OP_TICK:  f_item_next.kind = cldr_pkg::KIND_TICK;
            default:            f_item_next.kind = cldr_pkg::KIND_NONE;
        endcase
    end

    // Stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (accept)
            f_valid_reg <= 1'b1;
        else if (q_push)
            f_valid_reg <= 1'b0;
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
            f_item_reg <= f_item_next;
    end

endmodule

>>> hw/rtl/cldr_queue.sv
// ----------------------------------------------------------------------------
// cldr_queue
// Two-entry item queue between the input stage and the sequencer, so that
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module cldr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cldr_pkg::cldr_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output cldr_pkg::cldr_item_t head_item
);

    cldr_pkg::cldr_item_t entry_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> hw/rtl/cldr_back.sv
// ----------------------------------------------------------------------------
// cldr_back
// Sequencer: executes one item per cycle when not stalled, against the shadow text,
// dirty flags and LCD bus timer, and registers the pin levels as the result.
// ----------------------------------------------------------------------------
`include "char_lcd_dirty_refresh_macros.svh"

module cldr_back #(
    parameter int CELL_COUNT = cldr_pkg::CELL_COUNT_DEF,
    parameter int ROW_LENGTH = cldr_pkg::ROW_LENGTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cldr_pkg::cldr_cfg_t  cfg,
    input  logic                 q_valid,
    input  cldr_pkg::cldr_item_t q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [3:0]           data_nibble,
    output logic                 reg_select,
    output logic                 enable_line,
    output logic                 busy_res
);

    localparam int IDX_W     = $clog2(CELL_COUNT);
    localparam int ROW_COUNT = (CELL_COUNT + ROW_LENGTH - 1) / ROW_LENGTH;
    localparam int ROW_W     = $clog2(ROW_COUNT + 1);

    // Execute stage
    logic                 e_valid_reg;
    cldr_pkg::cldr_item_t e_item_reg;
    logic                 e_valid_next;
    cldr_pkg::cldr_item_t e_item_next;
    logic                 e_fire;
    logic                 e_load;
    logic                 out_ready;

    // Sequencer state
    logic [4:0]            phase_reg, phase_next;
    logic [1:0]            ps_reg, ps_next;
    logic [16:0]           wc_reg, wc_next;
    logic [8:0]            cb_reg, cb_next;
    logic [5:0]            pins_reg, pins_next;
    logic [CELL_COUNT-1:0] dirty_reg, dirty_next;
    logic [CELL_COUNT-1:0] cell_valid_reg, cell_valid_next;
    logic                  clear_pending_reg, clear_pending_next;
    logic [IDX_W-1:0]      lcd_addr_reg, lcd_addr_next;
    logic                  addr_known_reg, addr_known_next;
    logic                  busy_next;

    // Shadow text memory with registered read
    logic [7:0]       shadow_mem [CELL_COUNT];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic [IDX_W-1:0] ra_addr;
    logic [IDX_W-1:0] first_dirty;
    logic             mem_we;
    logic [7:0]       mem_wdata;
    logic [7:0]       sh_q;

    // Output register
    logic       out_valid_reg;
    logic [3:0] out_nib_reg;
    logic       out_rs_reg;
    logic       out_e_reg;
    logic       out_busy_reg;

    // Address helpers
    logic [ROW_W-1:0] row_v;
    logic [6:0]       col_v;
    logic [6:0]       ddram;
    logic             last_cell;

    // Timer helpers
    logic [16:0] wc_inc;
    logic [16:0] settle;
    logic [16:0] target;
    logic        do_disp;

    assign out_ready = ~out_valid_reg | ~out_stall;
    assign e_fire    = e_valid_reg & out_ready;
    assign e_load    = ~e_valid_reg | e_fire;
    assign q_pop     = e_load & q_valid;

    assign e_valid_next = e_load ? q_valid : e_valid_reg;
    assign e_item_next  = (e_load && q_valid) ? q_item : e_item_reg;

    // Cell value seen by the item in execute; cleared or unwritten cells read zero
    assign sh_q = cell_valid_reg[rd_addr_reg] ? rd_data_reg : 8'd0;

    // DDRAM address of the cell at the read address
    always_comb
    begin
        row_v = '0;
        for (int r = 1; r < ROW_COUNT; r++)
        begin
            if (int'(rd_addr_reg) >= r * ROW_LENGTH)
                row_v = row_v + ROW_W'(1);
        end
        col_v = 7'(int'(rd_addr_reg) - int'(row_v) * ROW_LENGTH);
        ddram = 7'((row_v[0] ? 32'h40 : 32'h00) + int'(row_v >> 1) * ROW_LENGTH
                   + int'(col_v));
    end

    // Flag the last column of a row or the last cell
    always_comb
    begin
        last_cell = (int'(lcd_addr_reg) == CELL_COUNT - 1);
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            if (int'(lcd_addr_reg) == r * ROW_LENGTH + ROW_LENGTH - 1)
                last_cell = 1'b1;
        end
    end

    // Settle time of the nibble that is in flight
    always_comb
    begin
        if (phase_reg >= cldr_pkg::PH_INIT_FIRST && phase_reg <= cldr_pkg::PH_INIT_LAST)
        begin
            case (cldr_pkg::init_settle(4'(phase_reg - cldr_pkg::PH_INIT_FIRST)))
                cldr_pkg::SETTLE_SHORT: settle = cldr_pkg::SHORT_SETTLE_US;
                cldr_pkg::SETTLE_LONG:  settle = cldr_pkg::LONG_SETTLE_US;
                cldr_pkg::SETTLE_FIRST: settle = 17'(cfg.init_first_wait_us);
                cldr_pkg::SETTLE_CLEAR: settle = 17'(cfg.clear_settle_us);
                default:                settle = cldr_pkg::SHORT_SETTLE_US;
            endcase
        end
        else if (phase_reg == cldr_pkg::PH_HIGH)
            settle = cldr_pkg::SHORT_SETTLE_US;
        else if (cb_reg == cldr_pkg::BYTE_CLEAR_DISPLAY)
            settle = 17'(cfg.clear_settle_us);
        else
            settle = 17'(cfg.char_settle_us);
    end

    assign wc_inc = (wc_reg == cldr_pkg::COUNT_MAX) ? wc_reg : wc_reg + 17'd1;
    assign target = (ps_reg < 2'd2) ? 17'(cfg.enable_pulse_us) : settle;

    // Execute one item: buffer update, clear request or timer tick
    always_comb
    begin
        phase_next         = phase_reg;
        ps_next            = ps_reg;
        wc_next            = wc_reg;
        cb_next            = cb_reg;
        pins_next          = pins_reg;
        dirty_next         = dirty_reg;
        cell_valid_next    = cell_valid_reg;
        clear_pending_next = clear_pending_reg;
        lcd_addr_next      = lcd_addr_reg;
        addr_known_next    = addr_known_reg;
        mem_we             = 1'b0;
        mem_wdata          = e_item_reg.char_code;
        do_disp            = 1'b0;

        if (e_fire)
        begin
            case (e_item_reg.kind)
                cldr_pkg::KIND_WRITE:
                begin
                    if (sh_q != e_item_reg.char_code)
                        dirty_next[rd_addr_reg] = 1'b1;
                    cell_valid_next[rd_addr_reg] = 1'b1;
                    mem_we = 1'b1;
                end
                cldr_pkg::KIND_CLEAR:
                begin
                    cell_valid_next    = '0;
                    clear_pending_next = 1'b1;
                end
                cldr_pkg::KIND_TICK:
                begin
                    if (phase_reg == cldr_pkg::PH_IDLE)
                        do_disp = 1'b1;
                    else if (phase_reg == cldr_pkg::PH_POWER)
                    begin
                        wc_next = wc_inc;
                        if (wc_inc >= cfg.power_on_wait_us)
                        begin
                            phase_next = cldr_pkg::PH_INIT_FIRST;
                            pins_next  = {2'b00, cldr_pkg::init_nibble(4'd0)};
                            ps_next    = 2'd0;
                            wc_next    = '0;
                        end
                    end
                    else
                    begin
                        wc_next = wc_inc;
                        if (wc_inc >= target)
                        begin
                            wc_next = '0;
                            case (ps_reg)
                                2'd0:
                                begin
                                    pins_next[5] = 1'b1;
                                    ps_next      = 2'd1;
                                end
                                2'd1:
                                begin
                                    pins_next[5] = 1'b0;
                                    ps_next      = 2'd2;
                                end
                                default:
                                begin
                                    if (phase_reg < cldr_pkg::PH_INIT_LAST)
                                    begin
                                        phase_next = phase_reg + 5'd1;
                                        pins_next  = {2'b00,
                                                      cldr_pkg::init_nibble(4'(phase_reg))};
                                        ps_next    = 2'd0;
                                    end
                                    else if (phase_reg == cldr_pkg::PH_INIT_LAST)
                                    begin
                                        phase_next      = cldr_pkg::PH_IDLE;
                                        lcd_addr_next   = '0;
                                        addr_known_next = 1'b1;
                                        do_disp         = 1'b1;
                                    end
                                    else if (phase_reg == cldr_pkg::PH_HIGH)
                                    begin
                                        phase_next = cldr_pkg::PH_LOW;
                                        pins_next  = {1'b0, cb_reg[8], cb_reg[3:0]};
                                        ps_next    = 2'd0;
                                    end
                                    else
                                    begin
                                        // Track the LCD address counter after the byte
                                        if (cb_reg[8])
                                        begin
                                            if (last_cell)
                                                addr_known_next = 1'b0;
                                            else
                                                lcd_addr_next = lcd_addr_reg + IDX_W'(1);
                                        end
                                        else if (cb_reg == cldr_pkg::BYTE_CLEAR_DISPLAY)
                                        begin
                                            lcd_addr_next   = '0;
                                            addr_known_next = 1'b1;
                                        end
                                        else
                                            addr_known_next = 1'b1;
                                        phase_next = cldr_pkg::PH_IDLE;
                                        do_disp    = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                end
                default: ;
            endcase

            // Start the next byte: pending clear first, then the lowest dirty cell
            if (do_disp)
            begin
                if (clear_pending_next || (|dirty_next))
                begin
                    if (clear_pending_next)
                    begin
                        clear_pending_next = 1'b0;
                        cb_next            = cldr_pkg::BYTE_CLEAR_DISPLAY;
                    end
                    else if (addr_known_next && lcd_addr_next == rd_addr_reg)
                    begin
                        dirty_next[rd_addr_reg] = 1'b0;
                        cb_next                 = {1'b1, sh_q};
                    end
                    else
                    begin
                        cb_next         = {cldr_pkg::SET_ADDRESS_TOP, ddram};
                        lcd_addr_next   = rd_addr_reg;
                        addr_known_next = 1'b0;
                    end
                    phase_next = cldr_pkg::PH_HIGH;
                    pins_next  = {1'b0, cb_next[8], cb_next[7:4]};
                    ps_next    = 2'd0;
                    wc_next    = '0;
                end
            end
        end

        busy_next = (phase_next != cldr_pkg::PH_IDLE) | clear_pending_next | (|dirty_next);
    end

    // Find the lowest dirty cell for the next item
    always_comb
    begin
        first_dirty = '0;
        for (int k = CELL_COUNT - 1; k >= 0; k--)
        begin
            if (dirty_next[k])
                first_dirty = IDX_W'(k);
        end
    end

    // Read for the item entering execute: the cell a write targets or a tick may send
    assign ra_addr = (e_item_next.kind == cldr_pkg::KIND_TICK) ? first_dirty
                                                               : IDX_W'(e_item_next.position);

    // Shadow memory write and registered read with write bypass
    always_ff @(posedge clk)
    begin
        if (mem_we)
            shadow_mem[rd_addr_reg] <= mem_wdata;
        if (mem_we && rd_addr_reg == ra_addr)
            rd_data_reg <= mem_wdata;
        else
            rd_data_reg <= shadow_mem[ra_addr];
        rd_addr_reg <= ra_addr;
    end

    // Execute stage and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg       <= 1'b0;
            phase_reg         <= cldr_pkg::PH_POWER;
            ps_reg            <= 2'd0;
            wc_reg            <= '0;
            cb_reg            <= '0;
            pins_reg          <= '0;
            dirty_reg         <= '0;
            cell_valid_reg    <= '0;
            clear_pending_reg <= 1'b0;
            lcd_addr_reg      <= '0;
            addr_known_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            e_valid_reg       <= e_valid_next;
            phase_reg         <= phase_next;
            ps_reg            <= ps_next;
            wc_reg            <= wc_next;
            cb_reg            <= cb_next;
            pins_reg          <= pins_next;
            dirty_reg         <= dirty_next;
            cell_valid_reg    <= cell_valid_next;
            clear_pending_reg <= clear_pending_next;
            lcd_addr_reg      <= lcd_addr_next;
            addr_known_reg    <= addr_known_next;
            if (e_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Item in execute and result payload
    always_ff @(posedge clk)
    begin
        e_item_reg <= e_item_next;
        if (e_fire)
        begin
            out_nib_reg  <= pins_next[3:0];
            out_rs_reg   <= pins_next[4];
            out_e_reg    <= pins_next[5];
            out_busy_reg <= busy_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_nibble = out_nib_reg;
    assign reg_select  = out_rs_reg;
    assign enable_line = out_e_reg;
    assign busy_res    = out_busy_reg;

    // Checks on the sequencer
    `CLDR_ASSERT_SAME(a_pulse_stage_range, 1'b1, ps_reg != 2'd3, "pulse stage out of range")
    `CLDR_ASSERT_SAME(a_idle_enable_low, phase_reg == cldr_pkg::PH_IDLE, !pins_reg[5], "E high while idle")
    `CLDR_ASSERT_NEXT(a_clear_queued, e_fire && e_item_reg.kind == cldr_pkg::KIND_CLEAR, clear_pending_reg, "clear not queued")
    `CLDR_ASSERT_NEXT(a_result_loaded, e_fire, out_valid_reg, "executed item gave no result")

endmodule

>>> hw/rtl/char_lcd_dirty_refresh.sv
// ----------------------------------------------------------------------------
// char_lcd_dirty_refresh
// Shadow-buffered refresh engine for a 4-bit character LCD.
// ----------------------------------------------------------------------------
// Takes one item per clock when not stalled and gives one result per item.
// Each item passes the input stage, queue and execute stage into the output
// register, which holds the result until it is taken. The rate is set by
// the execute stage, which retires one item a cycle unless the output stalls,
// reading the shadow text memory as each item enters it. A flip-flop valid bit
// per cell clears the text, so no clearing pass follows reset.
// Configuration writes are taken at any time and must be made while idle.
module char_lcd_dirty_refresh #(
    parameter int CELL_COUNT = cldr_pkg::CELL_COUNT_DEF,
    parameter int ROW_LENGTH = cldr_pkg::ROW_LENGTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [4:0]  position,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  data_nibble,
    output logic        reg_select,
    output logic        enable_line,
    output logic        busy_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    cldr_pkg::cldr_cfg_t  cfg_reg;
    cldr_pkg::cldr_item_t push_item;
    cldr_pkg::cldr_item_t head_item;
    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 head_valid;

    assign cfg_ready = 1'b1;

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_pulse_us    <= cldr_pkg::ENABLE_PULSE_RST;
            cfg_reg.char_settle_us     <= cldr_pkg::CHAR_SETTLE_RST;
            cfg_reg.clear_settle_us    <= cldr_pkg::CLEAR_SETTLE_RST;
            cfg_reg.power_on_wait_us   <= cldr_pkg::POWER_WAIT_RST;
            cfg_reg.init_first_wait_us <= cldr_pkg::INIT_FIRST_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cldr_pkg::CFG_ENABLE_PULSE: cfg_reg.enable_pulse_us    <= cfg_data[7:0];
                cldr_pkg::CFG_CHAR_SETTLE:  cfg_reg.char_settle_us     <= cfg_data[15:0];
                cldr_pkg::CFG_CLEAR_SETTLE: cfg_reg.clear_settle_us    <= cfg_data[15:0];
                cldr_pkg::CFG_POWER_WAIT:   cfg_reg.power_on_wait_us   <= cfg_data;
                cldr_pkg::CFG_INIT_FIRST:   cfg_reg.init_first_wait_us <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    cldr_front #(
        .CELL_COUNT (CELL_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .position  (position),
        .char_code (char_code),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    cldr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    cldr_back #(
        .CELL_COUNT (CELL_COUNT),
        .ROW_LENGTH (ROW_LENGTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (head_valid),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_nibble (data_nibble),
        .reg_select  (reg_select),
        .enable_line (enable_line),
        .busy_res    (busy_res)
    );

endmodule

>>> bench/lcd_refresh_checker.sv
// ----------------------------------------------------------------------------
// lcd_refresh_checker
// Predicts the LCD pin levels for each accepted item and checks every result.
// ----------------------------------------------------------------------------
// Keeps its own shadow text, dirty flags, bus sequencer and timing registers.
// The copy steps once per accepted item and follows every register write.
// Results are matched in order against the oldest prediction, field by field.
// The top reads the failure count and the number of results still owed.
module lcd_refresh_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  op,
    input  logic [4:0]  position,
    input  logic [7:0]  char_code,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  data_nibble,
    input  logic        reg_select,
    input  logic        enable_line,
    input  logic        busy_res,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    localparam int CELLS = cldr_pkg::CELL_COUNT_DEF;
    localparam int ROW   = cldr_pkg::ROW_LENGTH_DEF;
    localparam int BRINGUP_NIBBLES = 14;
    localparam logic [8:0] SET_DDRAM    = 9'h080;
    localparam logic [8:0] DATA_FLAG    = 9'h100;
    localparam logic [6:0] ODD_ROW_BASE = 7'h40;

    typedef struct packed {
        logic [3:0] nibble;
        logic       rs;
        logic       strobe;
        logic       busy;
    } lcd_pins_t;

    // Panel copy
    cldr_pkg::cldr_cfg_t timing;
    logic [7:0]          screen_text [CELLS];
    logic [CELLS-1:0]    stale_cells;
    logic                clear_queued;
    logic [4:0]          panel_addr;
    logic                addr_known;
    logic [4:0]          seq_phase;
    logic [8:0]          cur_byte;
    logic [16:0]         wait_count;
    logic [5:0]          pin_levels;
    logic [1:0]          pulse_stage;

    lcd_pins_t expected_pins [$];

    // Nibbles of the 4-bit bring-up sequence
    function automatic logic [3:0] bringup_nibble(input int idx);
        logic [3:0] nib;
        case (idx)
            0, 1, 2: nib = 4'h3;
            3, 4:    nib = 4'h2;
            5, 7:    nib = 4'h8;
            9:       nib = 4'h1;
            11:      nib = 4'h6;
            13:      nib = 4'hC;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    // Settle class that follows each bring-up nibble
    function automatic cldr_pkg::cldr_settle_t bringup_settle(input int idx);
        cldr_pkg::cldr_settle_t s;
        case (idx)
            0:                      s = cldr_pkg::SETTLE_FIRST;
            1, 2, 3, 5, 7, 11, 13:  s = cldr_pkg::SETTLE_LONG;
            9:                      s = cldr_pkg::SETTLE_CLEAR;
            default:                s = cldr_pkg::SETTLE_SHORT;
        endcase
        return s;
    endfunction

    function automatic void power_up_panel();
        int i;
        timing.enable_pulse_us    = cldr_pkg::ENABLE_PULSE_RST;
        timing.char_settle_us     = cldr_pkg::CHAR_SETTLE_RST;
        timing.clear_settle_us    = cldr_pkg::CLEAR_SETTLE_RST;
        timing.power_on_wait_us   = cldr_pkg::POWER_WAIT_RST;
        timing.init_first_wait_us = cldr_pkg::INIT_FIRST_RST;
        for (i = 0; i < CELLS; i++)
            screen_text[i] = '0;
        stale_cells  = '0;
        clear_queued = 1'b0;
        panel_addr   = '0;
        addr_known   = 1'b0;
        seq_phase    = cldr_pkg::PH_POWER;
        cur_byte     = '0;
        wait_count   = '0;
        pin_levels   = '0;
        pulse_stage  = '0;
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [16:0] value);
        case (idx)
            cldr_pkg::CFG_ENABLE_PULSE: timing.enable_pulse_us    = value[7:0];
            cldr_pkg::CFG_CHAR_SETTLE:  timing.char_settle_us     = value[15:0];
            cldr_pkg::CFG_CLEAR_SETTLE: timing.clear_settle_us    = value[15:0];
            cldr_pkg::CFG_POWER_WAIT:   timing.power_on_wait_us   = value;
            cldr_pkg::CFG_INIT_FIRST:   timing.init_first_wait_us = value[15:0];
            default: ;
        endcase
    endfunction

    function automatic void drive_nibble(input logic [3:0] nib, input logic rs);
        pin_levels  = {1'b0, rs, nib};
        pulse_stage = '0;
        wait_count  = '0;
    endfunction

    function automatic int settle_us();
        if (seq_phase >= cldr_pkg::PH_INIT_FIRST && seq_phase <= cldr_pkg::PH_INIT_LAST)
        begin
            case (bringup_settle(int'(seq_phase) - 1))
                cldr_pkg::SETTLE_SHORT: return int'(cldr_pkg::SHORT_SETTLE_US);
                cldr_pkg::SETTLE_LONG:  return int'(cldr_pkg::LONG_SETTLE_US);
                cldr_pkg::SETTLE_FIRST: return int'(timing.init_first_wait_us);
                default:                return int'(timing.clear_settle_us);
            endcase
        end
        if (seq_phase == cldr_pkg::PH_HIGH)
            return int'(cldr_pkg::SHORT_SETTLE_US);
        if (cur_byte == cldr_pkg::BYTE_CLEAR_DISPLAY)
            return int'(timing.clear_settle_us);
        return int'(timing.char_settle_us);
    endfunction

    // Pick the next byte: a queued clear, else the lowest dirty cell
    function automatic void start_next_byte();
        int i;
        int lowest;
        int row;
        int col;
        logic [6:0] ddram;
        lowest = -1;
        if (clear_queued)
        begin
            clear_queued = 1'b0;
            cur_byte = cldr_pkg::BYTE_CLEAR_DISPLAY;
        end
        else
        begin
            for (i = 0; i < CELLS; i++)
                if (stale_cells[i] && lowest < 0)
                    lowest = i;
            if (lowest < 0)
                return;
            if (addr_known && int'(panel_addr) == lowest)
            begin
                stale_cells[lowest] = 1'b0;
                cur_byte = DATA_FLAG | {1'b0, screen_text[lowest]};
            end
            else
            begin
                // Address counter elsewhere: move it first
                row = lowest / ROW;
                col = lowest % ROW;
                ddram = ((row % 2) != 0 ? ODD_ROW_BASE : 7'h00) + 7'((row / 2) * ROW + col);
                cur_byte = SET_DDRAM | {2'b00, ddram};
                panel_addr = 5'(lowest);
                addr_known = 1'b0;
            end
        end
        seq_phase = cldr_pkg::PH_HIGH;
        drive_nibble(cur_byte[7:4], cur_byte[8]);
    endfunction

    // Track where the display's address counter ends up
    function automatic void retire_byte();
        if (cur_byte[8])
        begin
            if (int'(panel_addr) % ROW == ROW - 1 || int'(panel_addr) + 1 >= CELLS)
                addr_known = 1'b0;
            else
                panel_addr = panel_addr + 5'd1;
        end
        else if (cur_byte == cldr_pkg::BYTE_CLEAR_DISPLAY)
        begin
            panel_addr = '0;
            addr_known = 1'b1;
        end
        else
            addr_known = 1'b1;
    endfunction

    // One microsecond of bus sequencing
    function automatic void tick_sequencer();
        int target;
        if (seq_phase == cldr_pkg::PH_IDLE)
        begin
            start_next_byte();
            return;
        end
        if (wait_count < cldr_pkg::COUNT_MAX)
            wait_count = wait_count + 17'd1;
        if (seq_phase == cldr_pkg::PH_POWER)
        begin
            if (wait_count >= timing.power_on_wait_us)
            begin
                seq_phase = cldr_pkg::PH_INIT_FIRST;
                drive_nibble(bringup_nibble(0), 1'b0);
            end
            return;
        end
        target = (pulse_stage < 2) ? int'(timing.enable_pulse_us) : settle_us();
        if (int'(wait_count) < target)
            return;
        wait_count = '0;
        if (pulse_stage == 2'd0)
        begin
            pin_levels[5] = 1'b1;
            pulse_stage = 2'd1;
            return;
        end
        if (pulse_stage == 2'd1)
        begin
            pin_levels[5] = 1'b0;
            pulse_stage = 2'd2;
            return;
        end
        if (seq_phase <= cldr_pkg::PH_INIT_LAST)
        begin
            if (int'(seq_phase) < BRINGUP_NIBBLES)
            begin
                seq_phase = seq_phase + 5'd1;
                drive_nibble(bringup_nibble(int'(seq_phase) - 1), 1'b0);
            end
            else
            begin
                seq_phase = cldr_pkg::PH_IDLE;
                panel_addr = '0;
                addr_known = 1'b1;
                start_next_byte();
            end
        end
        else if (seq_phase == cldr_pkg::PH_HIGH)
        begin
            seq_phase = cldr_pkg::PH_LOW;
            drive_nibble(cur_byte[3:0], cur_byte[8]);
        end
        else
        begin
            retire_byte();
            seq_phase = cldr_pkg::PH_IDLE;
            start_next_byte();
        end
    endfunction

    // Apply one item to the panel copy and return the pins that follow
    function automatic lcd_pins_t advance_panel(input logic [1:0] kind, input logic [4:0] pos,
                                                input logic [7:0] code);
        int i;
        lcd_pins_t pins_after;
        case (kind)
            cldr_pkg::OP_WRITE:
            begin
                if (int'(pos) < CELLS)
                begin
                    if (screen_text[pos] != code)
                        stale_cells[pos] = 1'b1;
                    screen_text[pos] = code;
                end
            end
            cldr_pkg::OP_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_text[i] = '0;
                clear_queued = 1'b1;
            end
            cldr_pkg::OP_TICK:
                tick_sequencer();
            default: ;
        endcase
        pins_after.nibble = pin_levels[3:0];
        pins_after.rs     = pin_levels[4];
        pins_after.strobe = pin_levels[5];
        pins_after.busy   = (seq_phase != cldr_pkg::PH_IDLE) || clear_queued || (|stale_cells);
        return pins_after;
    endfunction

    function automatic void check_field(input string label, input logic [3:0] want,
                                        input logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, label, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        lcd_pins_t want;
        if (!rst_n)
        begin
            power_up_panel();
            expected_pins.delete();
            fail_count = 0;
            checked = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            // Check results before adding this edge's prediction
            if (out_valid && !out_stall)
            begin
                if (expected_pins.size() == 0)
                begin
                    $display("%0t: result with nothing expected: nibble %h rs %b e %b busy %b",
                             $time, data_nibble, reg_select, enable_line, busy_res);
                    fail_count++;
                end
                else
                begin
                    want = expected_pins.pop_front();
                    check_field("data_nibble", want.nibble, data_nibble);
                    check_field("reg_select", {3'b000, want.rs}, {3'b000, reg_select});
                    check_field("enable_line", {3'b000, want.strobe}, {3'b000, enable_line});
                    check_field("busy_res", {3'b000, want.busy}, {3'b000, busy_res});
                    checked++;
                end
            end
            if (in_valid && !in_stall)
                expected_pins.push_back(advance_panel(op, position, char_code));
            pending = expected_pins.size();
        end
    end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the character LCD dirty-refresh engine.
// ----------------------------------------------------------------------------
// Drives writes, clears and microsecond ticks in bursts with random gaps while
// the result side stalls on its own pattern. Timing registers are reprogrammed
// between phases, from their smallest to their largest values and zero. A
// separate checker predicts the pins and reports failures; this module only
// makes stimulus, watches for a hang and gives the verdict.
module tb_top;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int PULSE_MAX     = 255;
    localparam int SETTLE_MAX    = 65535;
    localparam int POWER_MAX     = 131071;
    localparam int HOLD_CYCLES   = 80;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int BRINGUP_TICKS = 770;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 25;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  op        = cldr_pkg::OP_TICK;
    logic [4:0]  position  = '0;
    logic [7:0]  char_code = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  data_nibble;
    logic        reg_select;
    logic        enable_line;
    logic        busy_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = cldr_pkg::CFG_ENABLE_PULSE;
    logic [16:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int items_sent    = 0;
    int ticks_offered = 0;
    int writes_done   = 0;
    int settings_used = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    logic [4:0] last_pos = '0;

    char_lcd_dirty_refresh uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .position    (position),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_nibble (data_nibble),
        .reg_select  (reg_select),
        .enable_line (enable_line),
        .busy_res    (busy_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    lcd_refresh_checker refresh_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .position    (position),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_nibble (data_nibble),
        .reg_select  (reg_select),
        .enable_line (enable_line),
        .busy_res    (busy_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item and return at the edge that takes it
    task automatic send_item(input logic [1:0] kind, input logic [4:0] pos, input logic [7:0] code);
        in_valid  <= 1'b1;
        op        <= kind;
        position  <= pos;
        char_code <= code;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        items_sent++;
        if (kind == cldr_pkg::OP_TICK)
            ticks_offered++;
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Send in bursts: short gaps mostly, now and then a long unbroken run
    task automatic offer(input logic [1:0] kind, input logic [4:0] pos, input logic [7:0] code);
        send_item(kind, pos, code);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
    endtask

    // Mostly ticks and text runs along a row, with clears and spare codes mixed in
    task automatic random_item(input int tick_pct);
        int roll;
        logic [1:0] kind;
        logic [4:0] pos;
        logic [7:0] code;
        roll = $urandom_range(0, 99);
        pos  = 5'($urandom_range(0, 31));
        code = 8'($urandom_range(0, 255));
        if (roll < tick_pct)
            kind = cldr_pkg::OP_TICK;
        else if (roll < 96)
        begin
            kind = cldr_pkg::OP_WRITE;
            if ($urandom_range(0, 1) == 1)
                pos = last_pos + 5'd1;
            // Reuse a few codes so that unchanged writes happen often
            if ($urandom_range(0, 2) == 0)
                code = ($urandom_range(0, 1) == 1) ? 8'h41 : 8'h00;
            last_pos = pos;
        end
        else if (roll < 98)
            kind = cldr_pkg::OP_CLEAR;
        else
            kind = OP_SPARE;
        offer(kind, pos, code);
    endtask

    // Hold off until every result is back, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[16:0];
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        writes_done++;
    endtask

    task automatic program_timing(input int pulse, input int char_settle, input int clear_settle,
                                  input int power_wait, input int first_wait);
        write_reg(cldr_pkg::CFG_ENABLE_PULSE, pulse);
        write_reg(cldr_pkg::CFG_CHAR_SETTLE, char_settle);
        write_reg(cldr_pkg::CFG_CLEAR_SETTLE, clear_settle);
        write_reg(cldr_pkg::CFG_POWER_WAIT, power_wait);
        write_reg(cldr_pkg::CFG_INIT_FIRST, first_wait);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Result side: stall patterns in spans, plus long hold-offs on request
    initial
    begin
        int style;
        int span;
        int step_no;
        int holds_served;
        logic stall_next;
        holds_served = 0;
        stall_next = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_requests != holds_served)
            begin
                holds_served++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(10, 60);
                // Cut the span short as soon as a long hold-off is asked for
                for (step_no = 0; step_no < span && hold_requests == holds_served; step_no++)
                begin
                    case (style)
                        0:       stall_next = 1'b0;
                        1:       stall_next = ($urandom_range(0, 2) == 0);
                        2:       stall_next = ~stall_next;
                        default: stall_next = ($urandom_range(0, 9) < 7);
                    endcase
                    out_stall <= stall_next;
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: end the run when no handshake completes for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, quiet, pending);
        $display("char_lcd_dirty_refresh regression: fail");
        $finish;
    end

    initial
    begin
        int phase_no;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Longest power-on wait while the buffer takes directed edits
        program_timing(1, 1, 3, POWER_MAX, 2);
        send_item(cldr_pkg::OP_TICK, 5'd0, 8'h00);
        send_item(cldr_pkg::OP_TICK, 5'd31, 8'hFF);
        send_item(cldr_pkg::OP_WRITE, 5'd0, 8'hFF);
        send_item(cldr_pkg::OP_WRITE, 5'd31, 8'h00);
        send_item(cldr_pkg::OP_WRITE, 5'd31, 8'h80);
        send_item(cldr_pkg::OP_WRITE, 5'd5, 8'h41);
        send_item(cldr_pkg::OP_WRITE, 5'd5, 8'h41);
        send_item(OP_SPARE, 5'd31, 8'hFF);
        send_item(cldr_pkg::OP_CLEAR, 5'd0, 8'h00);
        send_item(cldr_pkg::OP_WRITE, 5'd15, 8'h55);
        send_item(cldr_pkg::OP_WRITE, 5'd16, 8'h7E);
        send_item(cldr_pkg::OP_WRITE, 5'd17, 8'h7F);
        send_item(cldr_pkg::OP_TICK, 5'd10, 8'h5A);
        drain();

        // Zero power-on wait counts as one: the next tick starts bring-up
        program_timing(1, 1, 3, 0, 2);
        while (ticks_offered < BRINGUP_TICKS)
            random_item(92);
        drain();

        // Refresh phases over different timing settings
        for (phase_no = 0; phase_no < PHASES; phase_no++)
        begin
            case (phase_no)
                2:       program_timing(PULSE_MAX, SETTLE_MAX, SETTLE_MAX, POWER_MAX, SETTLE_MAX);
                3:       program_timing(1, 1, 1, 1, 1);
                5:       program_timing(0, 0, 0, 0, 0);
                default: program_timing($urandom_range(1, 3), $urandom_range(1, 8),
                                        $urandom_range(1, 12), $urandom_range(1, POWER_MAX),
                                        $urandom_range(1, SETTLE_MAX));
            endcase
            // Stall the result side long enough to back the block up
            if (phase_no == 1)
                hold_requests <= hold_requests + 1;
            repeat (PHASE_ITEMS)
                random_item(60);
            drain();
        end

        $display("Sent %0d items (%0d ticks), checked %0d results, %0d register writes",
                 items_sent, ticks_offered, checked, writes_done);
        $display("over %0d timing settings including the extremes and zero", settings_used);
        if (fail_count == 0 && pending == 0)
            $display("char_lcd_dirty_refresh regression: pass");
        else
            $display("char_lcd_dirty_refresh regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/cldr_pkg.sv
hw/rtl/cldr_front.sv
hw/rtl/cldr_queue.sv
hw/rtl/cldr_back.sv
hw/rtl/char_lcd_dirty_refresh.sv
bench/lcd_refresh_checker.sv
bench/tb_top.sv
